/* hw/rtl/fapp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fapp_pkg
// Shared types and constants for the frame average peak picker.
// ----------------------------------------------------------------------------
package fapp_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int SUM_W     = 24;
  localparam int WIN_W     = 16;
  localparam int MARGIN_W  = 8;
  localparam int FRAME_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_MARGIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACING   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_FRAMES = 2'd3;

  localparam logic [WIN_W-1:0]    WINDOW_LEN_RST    = 16'd1470;
  localparam logic [MARGIN_W-1:0] PEAK_MARGIN_RST   = 8'd10;
  localparam logic [WIN_W-1:0]    MIN_SPACING_RST   = 16'd10;
  localparam logic [WIN_W-1:0]    WARMUP_FRAMES_RST = 16'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL
  } fapp_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic commit;
  } fapp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close_hit;
    logic div_done;
    logic peak_hit;
    logic out_free;
  } fapp_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/frame_average_peak_picker.sv */
`default_nettype none
// Timing: a non-closing sample is taken in its accept beat; a closing sample takes its
//   accept beat, the bit-serial divider (24 steps) and the commit state, in which its
//   peak (if any) is loaded into the output register.
// Throughput: 1 sample per cycle inside a frame; a closing sample holds the input until
//   its frame commits, longer while an earlier peak still waits in the output register.
// Reset: synchronous active low; registers to defaults, all frame state zero.
// ----------------------------------------------------------------------------
// frame_average_peak_picker
// Frame averaging of 8-bit samples with local peak picking on the averages.
// ----------------------------------------------------------------------------
module frame_average_peak_picker
  import fapp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FRAME_W-1:0]        out_peak_frame,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  fapp_cmd_t cmd;
  fapp_sts_t sts;

  fapp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fapp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_peak_frame (out_peak_frame),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule
`default_nettype wire

/* hw/rtl/fapp_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fapp_div
// Restoring divider, one quotient bit per cycle, frame sum by window length.
// ----------------------------------------------------------------------------
module fapp_div
  import fapp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [WIN_W-1:0] divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WIN_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [WIN_W-1:0]     dsr_r;
  logic [WIN_W:0]       rem_sh;
  logic [WIN_W:0]       diff;

  always_comb begin
    rem_sh = {rem_r, quo_r[SUM_W-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    if (rem_sh >= {1'b0, dsr_r}) begin
      rem_nxt = diff[WIN_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[WIN_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

/* hw/rtl/fapp_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fapp_datapath
// Config registers, frame sum, average history, peak test and result register.
// ----------------------------------------------------------------------------
module fapp_datapath
  import fapp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fapp_cmd_t            cmd,
  output fapp_sts_t                 sts,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FRAME_W-1:0]        out_peak_frame,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic [WIN_W-1:0]    window_len_r;
  logic [MARGIN_W-1:0] peak_margin_r;
  logic [WIN_W-1:0]    min_spacing_r;
  logic [WIN_W-1:0]    warmup_r;

  logic [SUM_W-1:0]    sum_r;
  logic [WIN_W-1:0]    pos_r;
  logic                first_seen_r;
  logic [SAMPLE_W-1:0] middle_r, newest_r;
  logic [FRAME_W-1:0]  frame_cnt_r;
  logic [FRAME_W-1:0]  last_peak_r;
  logic                out_valid_r;
  logic [FRAME_W-1:0]  out_peak_frame_r;

  logic [WIN_W-1:0]    win_eff;
  logic [SUM_W-1:0]    sum_add;
  logic [WIN_W:0]      pos_inc;
  logic                close_hit;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;
  logic [SAMPLE_W-1:0] avg;
  logic [FRAME_W-1:0]  frame_cnt_nxt;
  logic [SAMPLE_W:0]   margin9;
  logic                left_ok, right_ok, spacing_ok, warm_ok, peak_hit;
  logic [FRAME_W-1:0]  peak_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r  <= WINDOW_LEN_RST;
      peak_margin_r <= PEAK_MARGIN_RST;
      min_spacing_r <= MIN_SPACING_RST;
      warmup_r      <= WARMUP_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LEN:    window_len_r  <= cfg_data;
        CFG_PEAK_MARGIN:   peak_margin_r <= cfg_data[MARGIN_W-1:0];
        CFG_MIN_SPACING:   min_spacing_r <= cfg_data;
        CFG_WARMUP_FRAMES: warmup_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    win_eff   = (window_len_r == '0) ? WIN_W'(1) : window_len_r;
    sum_add   = sum_r + SUM_W'(in_sample);
    pos_inc   = {1'b0, pos_r} + 1'b1;
    // wrap of the position counter also closes the frame
    close_hit = !first_seen_r || pos_inc[WIN_W] || (pos_inc[WIN_W-1:0] >= win_eff);
  end

  fapp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_add),
    .divisor  (win_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    avg = (quotient[SUM_W-1:SAMPLE_W] != '0) ? {SAMPLE_W{1'b1}} : quotient[SAMPLE_W-1:0];
    frame_cnt_nxt = (frame_cnt_r == {FRAME_W{1'b1}}) ? frame_cnt_r : frame_cnt_r + 1'b1;
    margin9    = {1'b0, peak_margin_r};
    // history after the shift: middle_r, newest_r, avg
    left_ok    = ({1'b0, middle_r} + margin9) < {1'b0, newest_r};
    right_ok   = {1'b0, newest_r} > ({1'b0, avg} + margin9);
    spacing_ok = ({1'b0, last_peak_r} + (FRAME_W+1)'(min_spacing_r))
                 <= {1'b0, frame_cnt_nxt};
    warm_ok    = frame_cnt_nxt >= FRAME_W'(warmup_r);
    peak_hit   = left_ok && right_ok && spacing_ok && warm_ok;
    peak_frame = frame_cnt_nxt - FRAME_W'(warmup_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      pos_r        <= '0;
      first_seen_r <= 1'b0;
      middle_r     <= '0;
      newest_r     <= '0;
      frame_cnt_r  <= '0;
      last_peak_r  <= '0;
    end else if (cmd.accept) begin
      sum_r <= sum_add;
      if (close_hit) begin
        pos_r        <= '0;
        first_seen_r <= 1'b1;
      end else begin
        pos_r <= pos_inc[WIN_W-1:0];
      end
    end else if (cmd.commit) begin
      sum_r       <= '0;
      middle_r    <= newest_r;
      newest_r    <= avg;
      frame_cnt_r <= frame_cnt_nxt;
      if (peak_hit) begin
        last_peak_r <= frame_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && peak_hit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && peak_hit) begin
      out_peak_frame_r <= peak_frame;
    end
  end

  assign sts.close_hit  = close_hit;
  assign sts.div_done   = div_done;
  assign sts.peak_hit   = peak_hit;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_peak_frame = out_peak_frame_r;

endmodule
`default_nettype wire

/* hw/rtl/fapp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fapp_ctrl
// Sequencer: take a sample, run the divider on frame close, commit the frame.
// ----------------------------------------------------------------------------
module fapp_ctrl
  import fapp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire fapp_sts_t sts,
  output fapp_cmd_t      cmd
);

  fapp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.close_hit) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // hold a peaking frame while a previous peak still waits in the output register
        if (!sts.peak_hit || sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Feeds 8-bit samples into the frame average peak picker through a directed
// plan and then random framed traffic under three idle mixes. An internal
// predictor computes the peak frames of the random traffic, the directed plan
// gives its own, and each output beat is checked against them in order.
// ----------------------------------------------------------------------------
module testbench
  import fapp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_SLACK   = 40;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_BLOCKS = 6;
  localparam int BLOCK_ITEMS   = 100;
  localparam int PLAN_ROWS     = 33;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PEAK} peak_chk_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DAT_W-1:0]  value;
    logic [SAMPLE_W-1:0]   sample;
    logic [16:0]           reps;
    peak_chk_t             chk;
    logic [FRAME_W-1:0]    peak;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  in_sample;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FRAME_W-1:0]   out_peak_frame;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // predictor copy of the registers and frame state
  logic [WIN_W-1:0]    win_len;
  logic [MARGIN_W-1:0] margin;
  logic [WIN_W-1:0]    spacing;
  logic [WIN_W-1:0]    warmup;
  logic [SUM_W-1:0]    acc;
  logic [WIN_W-1:0]    pos;
  bit                  primed;
  logic [7:0]          avg_old, avg_mid, avg_new;
  logic [FRAME_W-1:0]  frame_cnt, last_peak;

  logic [FRAME_W-1:0] pending_peaks [$];
  logic [FRAME_W-1:0] want_peak;
  plan_row_t          plan [PLAN_ROWS];

  int unsigned cycles = 0;
  int          errors = 0;
  int          samples_sent = 0;
  int          peaks_seen = 0;
  int          reg_writes = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;

  frame_average_peak_picker dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_peak_frame (out_peak_frame),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d peaks still pending", cycles,
               pending_peaks.size());
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic note_mismatch(input string detail);
    errors++;
    $display("[cycle %0d] mismatch: %s", cycles, detail);
  endtask

  // frame close: push the truncated average into the history, test for a peak
  function automatic bit close_average(output logic [FRAME_W-1:0] peak);
    int unsigned divisor;
    int unsigned quot;
    bit          hit;
    divisor = (win_len == '0) ? 1 : 32'(win_len);
    quot    = 32'(acc) / divisor;
    avg_old = avg_mid;
    avg_mid = avg_new;
    avg_new = (quot > 255) ? 8'hFF : quot[7:0];
    if (frame_cnt != '1) frame_cnt = frame_cnt + 1;
    hit = (32'(avg_old) + 32'(margin) < 32'(avg_mid)) &&
          (32'(avg_mid) > 32'(avg_new) + 32'(margin)) &&
          (64'(last_peak) + 64'(spacing) <= 64'(frame_cnt)) &&
          (frame_cnt >= 32'(warmup));
    peak = frame_cnt - 32'(warmup);
    if (hit) last_peak = frame_cnt;
    acc = '0;
    return hit;
  endfunction

  function automatic bit take_sample(input logic [SAMPLE_W-1:0] s,
                                     output logic [FRAME_W-1:0] peak);
    int unsigned divisor;
    peak    = '0;
    divisor = (win_len == '0) ? 1 : 32'(win_len);
    acc     = acc + SUM_W'(s);
    if (!primed) begin
      // very first sample closes a frame on its own
      primed = 1'b1;
      pos    = '0;
      return close_average(peak);
    end
    pos = pos + 16'd1;
    if (pos == '0 || 32'(pos) >= divisor) begin
      pos = '0;
      return close_average(peak);
    end
    return 1'b0;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW_LEN:    win_len = val;
      CFG_PEAK_MARGIN:   margin  = val[MARGIN_W-1:0];
      CFG_MIN_SPACING:   spacing = val;
      CFG_WARMUP_FRAMES: warmup  = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // stop offering, let every pending peak arrive and the divider finish
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input peak_chk_t chk,
                              input logic [FRAME_W-1:0] typed);
    logic [FRAME_W-1:0] pk;
    bit                 hit;
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    hit = take_sample(s, pk);
    case (chk)
      CHK_MODEL: if (hit) pending_peaks.push_back(pk);
      CHK_PEAK:  pending_peaks.push_back(typed);
      default: ;
    endcase
    samples_sent++;
  endtask

  // result side: check each beat, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_peaks.size() == 0) begin
          note_mismatch($sformatf("peak_frame %0d with nothing pending", out_peak_frame));
        end else begin
          want_peak = pending_peaks.pop_front();
          peaks_seen++;
          if (out_peak_frame !== want_peak)
            note_mismatch($sformatf("peak_frame got %0d want %0d", out_peak_frame, want_peak));
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    int         b;
    int         k;
    int         sent;
    int         flen;
    logic [7:0] level;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_WINDOW_LEN;
    cfg_data  = '0;

    win_len   = WINDOW_LEN_RST;
    margin    = PEAK_MARGIN_RST;
    spacing   = MIN_SPACING_RST;
    warmup    = WARMUP_FRAMES_RST;
    acc       = '0;
    pos       = '0;
    primed    = 1'b0;
    avg_old   = '0;
    avg_mid   = '0;
    avg_new   = '0;
    frame_cnt = '0;
    last_peak = '0;

    // history shown as oldest, middle, newest after each closing sample
    plan = '{
      // reset window: first sample closes with average 0
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd200, 17'd1,     CHK_NONE, 32'd0},
      // zero window acts as one sample per frame
      '{ROW_CFG,    CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_CFG,    CFG_PEAK_MARGIN,   16'd0,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_CFG,    CFG_MIN_SPACING,   16'd0,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd255, 17'd1,     CHK_NONE, 32'd0},
      // 0,255,0 at frame 3
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_PEAK, 32'd3},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      // full margin blocks even a 0 to 255 step
      '{ROW_CFG,    CFG_PEAK_MARGIN,   16'd255,   8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd255, 17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_CFG,    CFG_PEAK_MARGIN,   16'd254,   8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd255, 17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_PEAK, 32'd8},
      // warmup beyond the frame count
      '{ROW_CFG,    CFG_WARMUP_FRAMES, 16'd65535, 8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd255, 17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_CFG,    CFG_WARMUP_FRAMES, 16'd3,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      // spacing too wide since the peak at frame 8
      '{ROW_CFG,    CFG_MIN_SPACING,   16'd65535, 8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd255, 17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_CFG,    CFG_MIN_SPACING,   16'd2,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd255, 17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_PEAK, 32'd11},
      // shrink the window mid-frame: oversized average saturates to 255
      '{ROW_CFG,    CFG_WINDOW_LEN,    16'd100,   8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd255, 17'd99,    CHK_NONE, 32'd0},
      '{ROW_CFG,    CFG_WINDOW_LEN,    16'd2,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd255, 17'd1,     CHK_NONE, 32'd0},
      '{ROW_CFG,    CFG_WINDOW_LEN,    16'd1,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_PEAK, 32'd13},
      // wider window, one full frame of full-scale samples
      '{ROW_CFG,    CFG_WINDOW_LEN,    16'd40,    8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd255, 17'd40,    CHK_NONE, 32'd0},
      '{ROW_CFG,    CFG_WINDOW_LEN,    16'd1,     8'd0,   17'd1,     CHK_NONE, 32'd0},
      '{ROW_SAMPLE, CFG_WINDOW_LEN,    16'd0,     8'd0,   17'd1,     CHK_PEAK, 32'd15}
    };

    send_idle = 24;
    recv_idle = 67;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        quiesce();
        write_reg(plan[r].reg_idx, plan[r].value);
      end else begin
        for (k = 0; k < int'(plan[r].reps); k++)
          offer_sample(plan[r].sample, plan[r].chk, plan[r].peak);
      end
    end

    for (b = 0; b < RANDOM_BLOCKS; b++) begin
      quiesce();
      send_idle = (b < 2) ? 24 : (b < 4) ? 67 : 0;
      recv_idle = (b < 2) ? 67 : (b < 4) ? 24 : 0;
      if (b == 4) begin
        // dense peaks while the result side stalls, so the input backs up
        write_reg(CFG_WINDOW_LEN, 16'd1);
        write_reg(CFG_PEAK_MARGIN, 16'd0);
        write_reg(CFG_MIN_SPACING, 16'd0);
        write_reg(CFG_WARMUP_FRAMES, 16'd0);
        hold_req = 1'b1;
      end else begin
        write_reg(CFG_WINDOW_LEN, ($urandom_range(0, 4) == 0) ?
                  16'($urandom_range(0, 48)) : 16'($urandom_range(0, 4)));
        write_reg(CFG_PEAK_MARGIN, ($urandom_range(0, 5) == 0) ?
                  16'($urandom_range(0, 255)) : 16'($urandom_range(0, 20)));
        write_reg(CFG_MIN_SPACING, ($urandom_range(0, 5) == 0) ?
                  16'($urandom_range(0, 200)) : 16'($urandom_range(0, 4)));
        write_reg(CFG_WARMUP_FRAMES, ($urandom_range(0, 5) == 0) ?
                  16'($urandom_range(0, 2000)) : 16'($urandom_range(0, 6)));
      end
      sent = 0;
      while (sent < BLOCK_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          offer_sample(8'($urandom_range(0, 255)), CHK_MODEL, '0);
          sent++;
        end else begin
          // one frame at a loud or quiet level, low bits jittered
          level = ($urandom_range(0, 99) < 35) ? 8'($urandom_range(96, 255)) :
                                                 8'($urandom_range(0, 80));
          flen = (win_len == '0) ? 1 : int'(win_len);
          repeat (flen) begin
            offer_sample(level ^ 8'($urandom_range(0, 3)), CHK_MODEL, '0);
            sent++;
          end
        end
      end
    end
    quiesce();

    $display("covered %0d samples in %0d cycles with %0d register writes,", samples_sent,
             cycles, reg_writes);
    $display("window edge cases, average saturation and a stalled result side; %0d peaks",
             peaks_seen);
    if (errors == 0 && pending_peaks.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
